// ===== rtl/core/mp2a_pkg.sv =====
// Shared types, codes and constants of the 2-D max pooling block with argmax.
package mp2a_pkg;

  // Default sizes of the block
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int MAX_POOL_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIM_CFG_W  = 11;
  localparam int POOL_CFG_W = 4;

  localparam logic [DIM_CFG_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [DIM_CFG_W-1:0]  HEIGHT_RST = 11'd1024;
  localparam logic [POOL_CFG_W-1:0] POOL_RST   = 4'd2;
  localparam logic [POOL_CFG_W-1:0] STRIDE_RST = 4'd2;

  // Window offsets: up to 16 rows and columns, result reports the low 3 bits
  localparam int OFF_W  = 4;
  localparam int ARG_W  = 3;
  localparam int PCNT_W = 5;  // holds a clamped pool side up to 16

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_POOL   = 2'd2,
    REG_STRIDE = 2'd3
  } mp2a_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } mp2a_state_e;

  // Control that travels with each store read into the compare unit
  typedef struct packed {
    logic             load;
    logic             first;
    logic [OFF_W-1:0] row;
    logic [OFF_W-1:0] col;
  } mp2a_cmp_ctl_t;

endpackage

// ===== rtl/core/mp2a_store.sv =====
// Row ring store: one write port, one read port with registered read data.
module mp2a_store
  import mp2a_pkg::*;
#(
  parameter int AW = 13,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mp2a_cmp.sv =====
// Shared compare unit: keeps the running maximum of a window and its offsets.
module mp2a_cmp
  import mp2a_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mp2a_cmp_ctl_t                 ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] data_i,
  output logic signed [SAMPLE_BITS-1:0] best_o,
  output logic [OFF_W-1:0]              row_o,
  output logic [OFF_W-1:0]              col_o
);

  logic signed [SAMPLE_BITS-1:0] best_q;
  logic [OFF_W-1:0]              row_q, col_q;
  logic                          take;

  // strict compare: ties keep the earlier sample
  assign take = ctl_i.load && (ctl_i.first || (data_i > best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (take) begin
      row_q <= ctl_i.row;
      col_q <= ctl_i.col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q <= data_i;
    end
  end

  assign best_o = best_q;
  assign row_o  = row_q;
  assign col_o  = col_q;

endmodule

// ===== rtl/core/max_pool_2d_argmax.sv =====
// Top level of the 2-D max pooling block with argmax over a raster sample stream.
//
// Usage: samples of one image plane enter on the s_axis channel, one word each, in
// raster order; planes follow back to back and the position counters wrap after each.
// Each sample is written into a ring of MAX_POOL rows. A sample that is the bottom
// right corner of a window (origins on multiples of stride, no padding) starts a scan
// of the window: one store read per cycle through a single compare unit.
// Flow: a sample that completes no window is taken without a stall. A completing
// sample keeps s_axis_tready low through the scan of its window (the read port
// of the row store paces the scan) until the result, passed through the store
// read register and the compare register, is loaded into the output register.
// Output: m_axis_tdata carries max_value, arg_row, arg_col; tlast marks the final
// window of a plane. The result sits in an output register, so new samples are taken
// while it waits; a scan that finishes while the register is still full holds until
// the receiver takes the word. Configuration: cfg_we_i writes register cfg_addr_i
// (width, height, pool, stride); the user writes only while idle, and the block
// does not enforce it. Any write restarts the plane at row 0, column 0.
// Reset: clears the registers to 1024 x 1024, pool 2, stride 2, and the position.
// The row store is not cleared; a plane never reads an entry it has not written.
module max_pool_2d_argmax
  import mp2a_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int MAX_POOL    = MAX_POOL_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 2 * ARG_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // sample stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // max_value, arg_row, arg_col
  output logic                  m_axis_tlast    // plane_last
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;    // column index
  localparam int RCW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;  // row index
  localparam int PW   = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;      // ring row index
  localparam int WD   = CW + 1;
  localparam int HD   = RCW + 1;
  localparam int COW  = CW + 6;   // column origin arithmetic
  localparam int ROW  = RCW + 6;  // row origin arithmetic
  localparam int RS_W = PW + 2;
  localparam int AW   = PW + CW;
  localparam int DIM_CMP_W = 14;

  // ---------------------------------------------------------------- config
  logic [DIM_CFG_W-1:0]  width_q, height_q;
  logic [POOL_CFG_W-1:0] pool_q, stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      pool_q   <= POOL_RST;
      stride_q <= STRIDE_RST;
    end else if (cfg_we_i) begin
      unique case (mp2a_reg_e'(cfg_addr_i))
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_POOL:   pool_q   <= cfg_data_i[POOL_CFG_W-1:0];
        REG_STRIDE: stride_q <= cfg_data_i[POOL_CFG_W-1:0];
      endcase
    end
  end

  // Clamp the registers: zero reads as one, oversize saturates
  logic [WD-1:0]     w;
  logic [HD-1:0]     h;
  logic [PCNT_W-1:0] p;
  logic [POOL_CFG_W-1:0] s;

  always_comb begin
    if (width_q == '0) begin
      w = WD'(1);
    end else if (DIM_CMP_W'(width_q) > DIM_CMP_W'(MAX_WIDTH)) begin
      w = WD'(MAX_WIDTH);
    end else begin
      w = WD'(width_q);
    end
    if (height_q == '0) begin
      h = HD'(1);
    end else if (DIM_CMP_W'(height_q) > DIM_CMP_W'(MAX_HEIGHT)) begin
      h = HD'(MAX_HEIGHT);
    end else begin
      h = HD'(height_q);
    end
    if (pool_q == '0) begin
      p = PCNT_W'(1);
    end else if (PCNT_W'(pool_q) > PCNT_W'(MAX_POOL)) begin
      p = PCNT_W'(MAX_POOL);
    end else begin
      p = PCNT_W'(pool_q);
    end
    s = (stride_q == '0) ? POOL_CFG_W'(1) : stride_q;
  end

  // ---------------------------------------------------------------- position
  logic [CW-1:0]  col_q, col_d;
  logic [RCW-1:0] row_q, row_d;
  logic [PW-1:0]  ring_q, ring_d;
  logic [COW-1:0] corig_q, corig_d;   // next window origin column
  logic [ROW-1:0] rorig_q, rorig_d;   // next window origin row

  logic s_fire;
  logic col_end, row_end, col_hit, row_hit, hit;
  logic col_last, row_last;
  logic [PW-1:0] ring_inc;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign col_end = (COW'(col_q) + COW'(1)) == COW'(w);
  assign row_end = (ROW'(row_q) + ROW'(1)) == ROW'(h);
  assign col_hit = (COW'(col_q) + COW'(1)) == (corig_q + COW'(p));
  assign row_hit = (ROW'(row_q) + ROW'(1)) == (rorig_q + ROW'(p));
  assign hit     = col_hit && row_hit;
  // last origin when the next one would run past the plane edge
  assign col_last = (corig_q + COW'(s) + COW'(p)) > COW'(w);
  assign row_last = (rorig_q + ROW'(s) + ROW'(p)) > ROW'(h);
  assign ring_inc = (ring_q == PW'(MAX_POOL - 1)) ? '0 : ring_q + PW'(1);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    ring_d  = ring_q;
    corig_d = corig_q;
    rorig_d = rorig_q;
    if (cfg_we_i) begin
      col_d   = '0;
      row_d   = '0;
      ring_d  = '0;
      corig_d = '0;
      rorig_d = '0;
    end else if (s_fire) begin
      if (col_end) begin
        col_d   = '0;
        corig_d = '0;
        if (row_end) begin
          row_d   = '0;
          ring_d  = '0;
          rorig_d = '0;
        end else begin
          row_d  = row_q + RCW'(1);
          ring_d = ring_inc;
          if (row_hit) begin
            rorig_d = rorig_q + ROW'(s);
          end
        end
      end else begin
        col_d = col_q + CW'(1);
        if (col_hit) begin
          corig_d = corig_q + COW'(s);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      ring_q  <= '0;
      corig_q <= '0;
      rorig_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      ring_q  <= ring_d;
      corig_q <= corig_d;
      rorig_q <= rorig_d;
    end
  end

  // Ring row of the window's top row: ring - (p - 1), modulo MAX_POOL
  logic [RS_W-1:0] rs_sum, rs_wrap;
  assign rs_sum  = RS_W'(ring_q) + RS_W'(MAX_POOL) + RS_W'(1) - RS_W'(p);
  assign rs_wrap = (rs_sum >= RS_W'(MAX_POOL)) ? rs_sum - RS_W'(MAX_POOL) : rs_sum;

  // ---------------------------------------------------------------- sequencer
  mp2a_state_e state_q, state_d;
  logic        scan_end, out_free, out_load, rd_en;

  logic [OFF_W-1:0] si_q, si_d, sj_q, sj_d;
  logic [PW-1:0]    ring_i_q, ring_i_d;
  logic [CW-1:0]    orc_q;
  logic             last_q;
  logic [CW-1:0]    rd_col;
  logic             sj_end, si_end;

  assign sj_end   = PCNT_W'(sj_q) == (p - PCNT_W'(1));
  assign si_end   = PCNT_W'(si_q) == (p - PCNT_W'(1));
  assign scan_end = sj_end && si_end;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign rd_col   = CW'((CW + OFF_W)'(orc_q) + (CW + OFF_W)'(sj_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_fire && hit && !cfg_we_i) state_d = ST_SCAN;
      ST_SCAN:  if (scan_end) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SCAN:  rd_en = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load = out_free;
    endcase
  end

  // Walk the window row by row, column by column
  always_comb begin
    si_d     = si_q;
    sj_d     = sj_q;
    ring_i_d = ring_i_q;
    if (state_q == ST_IDLE) begin
      si_d     = '0;
      sj_d     = '0;
      ring_i_d = PW'(rs_wrap);
    end else if (rd_en) begin
      if (sj_end) begin
        sj_d     = '0;
        si_d     = si_q + OFF_W'(1);
        ring_i_d = (ring_i_q == PW'(MAX_POOL - 1)) ? '0 : ring_i_q + PW'(1);
      end else begin
        sj_d = sj_q + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      si_q     <= '0;
      sj_q     <= '0;
      ring_i_q <= '0;
    end else begin
      state_q  <= state_d;
      si_q     <= si_d;
      sj_q     <= sj_d;
      ring_i_q <= ring_i_d;
    end
  end

  // Window origin column and plane-end mark, captured with the completing sample
  always_ff @(posedge clk_i) begin
    if (s_fire && hit) begin
      orc_q  <= CW'(corig_q);
      last_q <= col_last && row_last;
    end
  end

  // ---------------------------------------------------------------- store
  logic [SAMPLE_BITS-1:0] rd_data;

  mp2a_store #(
    .AW (AW),
    .DW (SAMPLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s_fire),
    .waddr_i ({ring_q, col_q}),
    .wdata_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .re_i    (rd_en),
    .raddr_i ({ring_i_q, rd_col}),
    .rdata_o (rd_data)
  );

  // Control aligned with the registered read data
  mp2a_cmp_ctl_t ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.load  <= rd_en;
      ctl_q.first <= (si_q == '0) && (sj_q == '0);
      ctl_q.row   <= si_q;
      ctl_q.col   <= sj_q;
    end
  end

  logic signed [SAMPLE_BITS-1:0] best;
  logic [OFF_W-1:0]              best_row, best_col;

  mp2a_cmp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_q),
    .data_i (signed'(rd_data)),
    .best_o (best),
    .row_o  (best_row),
    .col_o  (best_col)
  );

  // ---------------------------------------------------------------- output
  logic                   m_valid_q;
  logic [SAMPLE_BITS-1:0] m_max_q;
  logic [ARG_W-1:0]       m_row_q, m_col_q;
  logic                   m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_max_q  <= best;
      m_row_q  <= best_row[ARG_W-1:0];
      m_col_q  <= best_col[ARG_W-1:0];
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({m_col_q, m_row_q, m_max_q});
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== rtl/core/mp2a_chk.sv =====
// Port-level checks of the max pooling block, bound to its top level.
module mp2a_chk
  import mp2a_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int OUT_W = ((SAMPLE_BITS + 2 * ARG_W + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  // no result word in the cycle after a reset edge
  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a new result only comes out of a window scan, when input was closed
  a_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a window scan");

  // no result word starts in the cycle after an accepted input word
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early after an input word");

endmodule

bind max_pool_2d_argmax mp2a_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mp2a_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the 2-D max pooling block with argmax on a raster stream.
module tb_top
  import mp2a_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Sizes the predictor works at; the instance runs with its default parameters.
  localparam int ROW_CAP     = MAX_WIDTH_DEF;
  localparam int COL_CAP     = MAX_HEIGHT_DEF;
  localparam int POOL_CAP    = MAX_POOL_DEF;
  localparam int STORE_DEPTH = MAX_POOL_DEF * MAX_WIDTH_DEF;
  // Longest scan (8 x 8 reads plus pipeline) with margin; wait this long before a write.
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_GUARD   = 200000;
  localparam int LONG_HOLD     = 300;

  // One expected result word
  typedef struct {
    logic signed [15:0] max_value;
    logic [2:0]         arg_row;
    logic [2:0]         arg_col;
    logic               plane_last;
  } window_t;

  // Clock, reset and block inputs, all known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;   // [15:0] sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;         // [15:0] max_value, [18:16] arg_row,
                                               // [21:19] arg_col, [23:22] zero
  logic                  m_axis_tlast;         // plane_last

  max_pool_2d_argmax dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Pooling predictor: its own copy of the registers, the row ring and the position.
  // ---------------------------------------------------------------------------------
  logic [DIM_CFG_W-1:0]  reg_width  = WIDTH_RST;
  logic [DIM_CFG_W-1:0]  reg_height = HEIGHT_RST;
  logic [POOL_CFG_W-1:0] reg_pool   = POOL_RST;
  logic [POOL_CFG_W-1:0] reg_stride = STRIDE_RST;
  logic signed [15:0]    ring_rows [0:STORE_DEPTH-1];
  int                    pos_row = 0;
  int                    pos_col = 0;

  window_t     window_q[$];   // expected window results, oldest first
  logic [15:0] sample_q[$];   // samples waiting for the driver

  // Zero counts as 1, anything above the cap saturates.
  function automatic int clamp_reg(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Store one sample, and if it closes a window, queue that window's max and argmax.
  task automatic pool_step(input logic signed [15:0] smp);
    int w, h, p, s, r, c, orr, orc, i, j, bi, bj, base;
    logic signed [15:0] best, v;
    window_t res;
    w = clamp_reg(reg_width, ROW_CAP);
    h = clamp_reg(reg_height, COL_CAP);
    p = clamp_reg(reg_pool, POOL_CAP);
    s = clamp_reg(reg_stride, 16);
    if (pos_row >= h) pos_row = 0;
    if (pos_col >= w) pos_col = 0;
    r = pos_row;
    c = pos_col;
    ring_rows[(r % POOL_CAP) * ROW_CAP + c] = smp;
    if (p <= w && p <= h && r + 1 >= p && c + 1 >= p) begin
      orr = r + 1 - p;
      orc = c + 1 - p;
      if (orr % s == 0 && orc % s == 0) begin
        // search starts at the top-left sample; strict compare keeps the first tie
        best = ring_rows[(orr % POOL_CAP) * ROW_CAP + orc];
        bi = 0;
        bj = 0;
        for (i = 0; i < p; i++) begin
          base = ((orr + i) % POOL_CAP) * ROW_CAP + orc;
          for (j = 0; j < p; j++) begin
            v = ring_rows[base + j];
            if (v > best) begin
              best = v;
              bi = i;
              bj = j;
            end
          end
        end
        res.max_value  = best;
        res.arg_row    = 3'(bi);
        res.arg_col    = 3'(bj);
        res.plane_last = (orr == ((h - p) / s) * s) && (orc == ((w - p) / s) * s);
        window_q.push_back(res);
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pos_row = r;
    pos_col = c;
  endtask

  // ---------------------------------------------------------------------------------
  // Sample driver: bursts of random length, random gaps between them. A word is held
  // until taken; the predictor runs on every accepted word.
  // ---------------------------------------------------------------------------------
  int burst_left    = 0;
  int gap_left      = 0;
  int samples_taken = 0;

  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pool_step(s_axis_tdata);
        samples_taken <= samples_taken + 1;
      end
      // only move on once the current word is gone (or there is none)
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            // a third of the bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Result receiver: stall pattern redrawn as the tick's low six bits wrap, plus long
  // hold-offs on request that fill the output register and stall the block's input.
  // ---------------------------------------------------------------------------------
  int         holds_requested = 0;
  int         holds_served    = 0;
  int         hold_left       = 0;
  logic [1:0] rx_mode         = '0;
  logic [7:0] rx_tick         = '0;

  always @(posedge clk_i or negedge rst_ni) begin : result_receiver
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      holds_served  <= 0;
      rx_mode       <= '0;
      rx_tick       <= '0;
    end else if (hold_left == 0 && holds_served != holds_requested) begin
      hold_left     <= LONG_HOLD;
      holds_served  <= holds_served + 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 8'd1;
      if (rx_tick[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
        2'd0:    m_axis_tready <= 1'b1;                         // no stalls
        2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));     // coin flip
        2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
        default: m_axis_tready <= (rx_tick[2:0] != 3'd0);       // one stall in eight
      endcase
    end
  end

  // ---------------------------------------------------------------------------------
  // Result monitor: compare each accepted word with the oldest expected window.
  // ---------------------------------------------------------------------------------
  int fail_count      = 0;
  int windows_checked = 0;

  always @(posedge clk_i) begin : result_monitor
    window_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (window_q.size() == 0) begin
        $error("result word with no window expected: data %h last %b",
               m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = window_q.pop_front();
        windows_checked <= windows_checked + 1;
        if ($signed(m_axis_tdata[15:0]) != want.max_value) begin
          $error("max_value: expected %0d, got %0d", want.max_value,
                 $signed(m_axis_tdata[15:0]));
          fail_count++;
        end
        if (m_axis_tdata[18:16] != want.arg_row) begin
          $error("arg_row: expected %0d, got %0d", want.arg_row, m_axis_tdata[18:16]);
          fail_count++;
        end
        if (m_axis_tdata[21:19] != want.arg_col) begin
          $error("arg_col: expected %0d, got %0d", want.arg_col, m_axis_tdata[21:19]);
          fail_count++;
        end
        if (m_axis_tlast != want.plane_last) begin
          $error("plane_last: expected %0d, got %0d", want.plane_last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------------
  int drain_errors  = 0;
  int setting_count = 0;

  // Hold until every sample is taken and every expected window has come back.
  task automatic drain_results();
    int guard;
    guard = 0;
    while ((sample_q.size() != 0 || s_axis_tvalid || window_q.size() != 0)
           && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= DRAIN_GUARD) begin
      $error("windows still outstanding: %0d", window_q.size());
      drain_errors++;
    end
  endtask

  // One register write; any write restarts the plane in the predictor as in the block.
  task automatic write_reg(input mp2a_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WIDTH:  reg_width  = val;
      REG_HEIGHT: reg_height = val;
      REG_POOL:   reg_pool   = val[3:0];
      default:    reg_stride = val[3:0];
    endcase
    pos_row = 0;
    pos_col = 0;
  endtask

  // Quiesce, then write all four registers. Pool and stride words sometimes carry
  // junk above bit 3, which the block must drop.
  task automatic apply_settings(input int w, input int h, input int p, input int s);
    logic [CFG_DATA_W-1:0] word;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
    word[3:0] = 4'(p);
    write_reg(REG_POOL, word);
    word = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
    word[3:0] = 4'(s);
    write_reg(REG_STRIDE, word);
    setting_count++;
  endtask

  // kind 0: full range; 1: extremes and a few values, many ties; 2: narrow band
  function automatic logic [15:0] gen_sample(input int kind);
    if (kind == 0) return 16'($urandom());
    if (kind == 1) begin
      case ($urandom_range(0, 5))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        2:       return 16'hffff;
        3:       return 16'h0000;
        4:       return 16'h0001;
        default: return 16'h0007;
      endcase
    end
    return 16'($signed($urandom_range(0, 7)) - 4);
  endfunction

  task automatic push_samples(input int n, input int kind);
    for (int k = 0; k < n; k++) sample_q.push_back(gen_sample(kind));
  endtask

  initial begin : stimulus
    int w, h, p, s, n, kind, area, random_items;
    bit late_hold_done;
    late_hold_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Two 2x2 windows side by side: max at the top-left with a later tie below it,
    // then a window of the most negative value with the max at the bottom-right.
    apply_settings(4, 2, 2, 2);
    sample_q.push_back(16'h7fff); sample_q.push_back(16'h8000);
    sample_q.push_back(16'h8000); sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7fff); sample_q.push_back(16'hffff);
    sample_q.push_back(16'h8000); sample_q.push_back(16'h7fff);

    // Zero width, height, pool and stride all act as 1: every sample is its own
    // window and the last of its plane.
    apply_settings(0, 0, 0, 0);
    sample_q.push_back(16'h0000); sample_q.push_back(16'hffff);
    sample_q.push_back(16'h7fff);

    // Pool above the cap saturates to 8, bigger than the 3x3 plane: no window ever.
    apply_settings(3, 3, 15, 1);
    push_samples(5, 0);

    // Rising ramp over one 3x3 window: the max sits at the bottom-right corner.
    apply_settings(3, 3, 3, 1);
    for (int k = 0; k < 9; k++) sample_q.push_back(16'(k * 1000 - 4000));

    // Pool 1 on a 6x6 plane: every sample yields a word, so a long receiver hold
    // fills the output register and the block has to push back on its input.
    apply_settings(6, 6, 1, 1);
    push_samples(72, 0);
    holds_requested++;

    // Width above the cap saturates to 1024; a full row plus the start of the next.
    apply_settings(2047, 1, 1, 15);
    push_samples(1030, 0);

    // Height above the cap saturates to 1024; only the top of that plane is sent.
    apply_settings(3, 2047, 2, 1);
    push_samples(30, 2);

    // Random settings, mostly small planes and small pools, one to two planes each,
    // usually ending part way into a plane so the next write cuts it short.
    random_items = 0;
    while (random_items < 250) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0:       p = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
        1, 2:    p = $urandom_range(5, 8);
        default: p = $urandom_range(1, 4);
      endcase
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      apply_settings(w, h, p, s);
      area = clamp_reg(w, ROW_CAP) * clamp_reg(h, COL_CAP);
      n = area + $urandom_range(0, area);
      if (n > 120) n = 120;
      kind = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) begin
        // pause the sender mid-plane until every window so far has come back
        push_samples(n / 2, kind);
        drain_results();
        push_samples(n - n / 2, kind);
      end else begin
        push_samples(n, kind);
      end
      if (!late_hold_done && random_items > 100) begin
        holds_requested++;
        late_hold_done = 1'b1;
      end
      random_items += n;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d samples and %0d windows over %0d register settings,",
             samples_taken, windows_checked, setting_count);
    $display("pool sides 1 to 8, clamped and saturated registers, ties and long stalls");
    if (fail_count == 0 && drain_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== max_pool_2d_argmax.f =====
rtl/core/mp2a_pkg.sv
rtl/core/mp2a_store.sv
rtl/core/mp2a_cmp.sv
rtl/core/max_pool_2d_argmax.sv
rtl/core/mp2a_chk.sv
tb/tb_top.sv
